FILE: hdl/dsa_pkg.sv
// Shared constants, operation codes and handshake structs of the descriptor slot allocator.
`default_nettype none

package dsa_pkg;

  // Table geometry
  localparam int unsigned ENTRIES     = 8192;
  localparam int unsigned IDX_W       = 13;
  localparam int unsigned IDX_AW      = $clog2(ENTRIES);
  localparam logic [IDX_W:0] ENTRY_END = (IDX_W + 1)'(ENTRIES);

  // Used map: 32-bit words, grouped sixteen words to a summary bit
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_AW      = 5;
  localparam int unsigned WORDS       = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned GROUP_WORDS = 16;
  localparam int unsigned SUB_AW      = 4;
  localparam int unsigned GROUPS      = (WORDS + GROUP_WORDS - 1) / GROUP_WORDS;
  localparam int unsigned GROUP_AW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // Operation codes
  localparam logic [1:0] KIND_ALLOC     = 2'd0;
  localparam logic [1:0] KIND_SET_BASE  = 2'd1;
  localparam logic [1:0] KIND_SET_LIMIT = 2'd2;
  localparam logic [1:0] KIND_FREE      = 2'd3;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Request into the used map: allocate lowest free entry, or free idx
  typedef struct packed {
    logic             start;
    logic             alloc;
    logic [IDX_W-1:0] idx;
  } map_req_t;

  // Response from the used map: one cycle pulse on done
  typedef struct packed {
    logic             done;
    logic             ok;
    logic [IDX_W-1:0] idx;
  } map_resp_t;

  // Bits of a map word that never take part: entry zero and entries past the table
  function automatic logic [WORD_BITS-1:0] pad_mask(input logic [WORD_AW-1:0] widx);
    logic [WORD_BITS-1:0] m;
    int unsigned          pos;
    m = '0;
    for (int unsigned b = 0; b < WORD_BITS; b++) begin
      pos  = int'(widx) * WORD_BITS + b;
      m[b] = (pos == 0) || (pos >= ENTRIES);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/descriptor_slot_allocator_core.sv
// Top level of the descriptor slot allocator: operation decode, field stores, result register.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries an operation beat with
// kind_i, selector_i, base_value_i and limit_value_i; one output channel
// (out_valid_o / out_stall_i) returns exactly one result beat per operation with
// status_o and selector_out_o. Items are worked on one at a time; in_stall_o is
// high while an item is in flight.
// From the accepting edge to the result register, an allocate steps through group
// summary pick, word pick with memory read, and bit pick and write-back; an
// allocate on a full table ends after the group summary pick; a free does only
// the write-back of the used word read at accept; set base, set limit and index
// zero take no map step. The next beat can be taken in the cycle after the
// result is registered. The registered read of the used-map word memory is what
// gives an allocate its separate word pick step.
// A finished result sits in an output register; while the receiver stalls it,
// a new beat is still taken and worked up to its result, which then waits.
// Reset clears the used map at once through per-word valid bits, so there is
// no clearing pass; base and limit stores are not cleared and are never read.
`default_nettype none

module descriptor_slot_allocator_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  kind_i,
  input  wire  [15:0] selector_i,
  input  wire  [31:0] base_value_i,
  input  wire  [31:0] limit_value_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        status_o,
  output logic [15:0] selector_out_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_DONE} state_e;

  state_e state_q;

  logic [1:0]  kind_q;
  logic [31:0] base_q;
  logic [31:0] limit_q;
  logic        res_status_q;
  logic [15:0] res_sel_q;
  logic        out_valid_q;
  logic        out_status_q;
  logic [15:0] out_sel_q;

  logic                      accept;
  logic                      out_free;
  logic                      out_load;
  logic [dsa_pkg::IDX_W-1:0] idx_in;
  logic                      idx_bad;
  logic                      wait_status;
  logic [15:0]               wait_sel;

  dsa_pkg::map_req_t  map_req;
  dsa_pkg::map_resp_t map_resp;

  logic [31:0] base_mem  [dsa_pkg::ENTRIES];
  logic [31:0] limit_mem [dsa_pkg::ENTRIES];

  logic                       base_we;
  logic                       limit_we;
  logic [dsa_pkg::IDX_AW-1:0] field_addr;
  logic [31:0]                base_wdata;
  logic [31:0]                limit_wdata;

  // Decode the incoming beat
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_in   = selector_i[15:3];
  assign idx_bad  = (idx_in == '0) || ({1'b0, idx_in} >= dsa_pkg::ENTRY_END);

  assign in_stall_o = (state_q != ST_IDLE);

  // Load the output register when a result is ready and the slot is free
  assign out_load = out_free &&
                    ((state_q == ST_WAIT && map_resp.done) || (state_q == ST_DONE));

  // Start the used map for allocate and for a valid free
  assign map_req.start = accept && ((kind_i == dsa_pkg::KIND_ALLOC) ||
                                    (kind_i == dsa_pkg::KIND_FREE && !idx_bad));
  assign map_req.alloc = (kind_i == dsa_pkg::KIND_ALLOC);
  assign map_req.idx   = idx_in;

  dsa_used_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .resp_o (map_resp)
  );

  // Form the result of a map operation
  assign wait_status = map_resp.ok ? dsa_pkg::STATUS_OK : dsa_pkg::STATUS_FAIL;
  assign wait_sel    = (kind_q == dsa_pkg::KIND_ALLOC && map_resp.ok) ?
                       {map_resp.idx, 3'b111} : '0;

  // Field store writes: set and free from the beat, allocate from the map result
  always_comb begin
    base_we     = 1'b0;
    limit_we    = 1'b0;
    field_addr  = idx_in[dsa_pkg::IDX_AW-1:0];
    base_wdata  = base_value_i;
    limit_wdata = limit_value_i;
    if (state_q == ST_IDLE) begin
      if (accept && !idx_bad) begin
        unique case (kind_i)
          dsa_pkg::KIND_SET_BASE:  base_we = 1'b1;
          dsa_pkg::KIND_SET_LIMIT: limit_we = 1'b1;
          dsa_pkg::KIND_FREE: begin
            base_we     = 1'b1;
            limit_we    = 1'b1;
            base_wdata  = '0;
            limit_wdata = '0;
          end
          default: ;
        endcase
      end
    end else if (state_q == ST_WAIT) begin
      field_addr  = map_resp.idx[dsa_pkg::IDX_AW-1:0];
      base_wdata  = base_q;
      limit_wdata = limit_q;
      if (map_resp.done && map_resp.ok && kind_q == dsa_pkg::KIND_ALLOC) begin
        base_we  = 1'b1;
        limit_we = 1'b1;
      end
    end
  end

  // Base and limit stores
  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_mem[field_addr] <= base_wdata;
    end
    if (limit_we) begin
      limit_mem[field_addr] <= limit_wdata;
    end
  end

  // Hold the operands of the beat in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      base_q  <= base_value_i;
      limit_q <= limit_value_i;
    end
  end

  // Control sequence and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      res_status_q <= dsa_pkg::STATUS_OK;
      res_sel_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= dsa_pkg::STATUS_OK;
      out_sel_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            priority if (kind_i == dsa_pkg::KIND_ALLOC) begin
              state_q <= ST_WAIT;
            end else if (idx_bad) begin
              res_status_q <= dsa_pkg::STATUS_FAIL;
              res_sel_q    <= '0;
              state_q      <= ST_DONE;
            end else if (kind_i == dsa_pkg::KIND_FREE) begin
              state_q <= ST_WAIT;
            end else begin
              res_status_q <= dsa_pkg::STATUS_OK;
              res_sel_q    <= '0;
              state_q      <= ST_DONE;
            end
          end
        end
        ST_WAIT: begin
          if (map_resp.done) begin
            if (out_free) begin
              out_status_q <= wait_status;
              out_sel_q    <= wait_sel;
              state_q      <= ST_IDLE;
            end else begin
              res_status_q <= wait_status;
              res_sel_q    <= wait_sel;
              state_q      <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_status_q <= res_status_q;
            out_sel_q    <= res_sel_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign selector_out_o = out_sel_q;

  // The map answers only while a map operation is outstanding
  a_resp_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_resp.done |-> (state_q == ST_WAIT))
    else $error("used map answered outside a map operation");

  // A successful map operation never lands on entry zero
  a_resp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_resp.done && map_resp.ok) |-> (map_resp.idx != '0))
    else $error("used map returned entry zero");

  // A failed operation carries a zero selector
  a_fail_zero_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == dsa_pkg::STATUS_FAIL) |-> (selector_out_o == '0))
    else $error("failure result with nonzero selector");

  // The used map is not started again in the cycle after it was started
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_req.start |=> !map_req.start)
    else $error("map started twice in a row");

endmodule

`default_nettype wire

FILE: hdl/dsa_used_map.sv
// Used-entry bitmap in a word memory with a two-level full summary and first-free search.
`default_nettype none

module dsa_used_map (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  dsa_pkg::map_req_t   req_i,
  output dsa_pkg::map_resp_t  resp_o
);

  typedef enum logic [1:0] {M_IDLE, M_GROUP, M_WORD, M_MOD} mstate_e;

  mstate_e mstate_q;

  logic [dsa_pkg::WORD_BITS-1:0] used_mem [dsa_pkg::WORDS];
  logic [dsa_pkg::WORD_BITS-1:0] rd_q;

  logic [dsa_pkg::WORDS-1:0]  word_valid_q;
  logic [dsa_pkg::WORDS-1:0]  word_full_q;
  logic [dsa_pkg::GROUPS-1:0] group_full_q;
  logic [dsa_pkg::GROUPS-1:0] group_full_d;
  logic [dsa_pkg::GROUPS*dsa_pkg::GROUP_WORDS-1:0] full_pad;

  logic [dsa_pkg::GROUP_AW-1:0]    grp_q;
  logic [dsa_pkg::GROUP_AW-1:0]    grp_pick;
  logic                            grp_any;
  logic [dsa_pkg::GROUP_WORDS-1:0] grp_slice;
  logic [dsa_pkg::SUB_AW-1:0]      sub_pick;
  logic [dsa_pkg::GROUP_AW+dsa_pkg::SUB_AW-1:0] word_pick_wide;
  logic [dsa_pkg::WORD_AW-1:0]     word_pick;

  logic [dsa_pkg::WORD_AW-1:0] widx_q;
  logic [dsa_pkg::BIT_AW-1:0]  bit_q;
  logic                        alloc_q;

  logic [dsa_pkg::WORD_BITS-1:0] cur_word;
  logic [dsa_pkg::WORD_BITS-1:0] word_pad;
  logic [dsa_pkg::WORD_BITS-1:0] masked;
  logic [dsa_pkg::WORD_BITS-1:0] bit_onehot;
  logic [dsa_pkg::WORD_BITS-1:0] new_word;
  logic [dsa_pkg::BIT_AW-1:0]    zero_pick;
  logic [dsa_pkg::BIT_AW-1:0]    bit_sel;
  logic                          new_full;

  logic                        mem_re;
  logic                        mem_we;
  logic [dsa_pkg::WORD_AW-1:0] mem_raddr;

  // Pad the full map so words past the table always look full
  always_comb begin
    full_pad = '1;
    full_pad[dsa_pkg::WORDS-1:0] = word_full_q;
    for (int unsigned g = 0; g < dsa_pkg::GROUPS; g++) begin
      group_full_d[g] = &full_pad[g*dsa_pkg::GROUP_WORDS +: dsa_pkg::GROUP_WORDS];
    end
  end

  // Pick the lowest group with a free word
  always_comb begin
    grp_pick = '0;
    grp_any  = 1'b0;
    for (int g = dsa_pkg::GROUPS - 1; g >= 0; g--) begin
      if (!group_full_q[g]) begin
        grp_pick = dsa_pkg::GROUP_AW'(g);
        grp_any  = 1'b1;
      end
    end
  end

  // Pick the lowest non-full word inside the chosen group
  always_comb begin
    for (int unsigned s = 0; s < dsa_pkg::GROUP_WORDS; s++) begin
      grp_slice[s] = full_pad[{grp_q, dsa_pkg::SUB_AW'(s)}];
    end
    sub_pick = '0;
    for (int s = dsa_pkg::GROUP_WORDS - 1; s >= 0; s--) begin
      if (!grp_slice[s]) begin
        sub_pick = dsa_pkg::SUB_AW'(s);
      end
    end
    word_pick_wide = {grp_q, sub_pick};
    word_pick      = word_pick_wide[dsa_pkg::WORD_AW-1:0];
  end

  // Modify the word read back: set the lowest clear bit, or clear the freed one
  always_comb begin
    cur_word  = word_valid_q[widx_q] ? rd_q : '0;
    word_pad  = dsa_pkg::pad_mask(widx_q);
    masked    = cur_word | word_pad;
    zero_pick = '0;
    for (int b = dsa_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (!masked[b]) begin
        zero_pick = dsa_pkg::BIT_AW'(b);
      end
    end
    bit_sel    = alloc_q ? zero_pick : bit_q;
    bit_onehot = dsa_pkg::WORD_BITS'(1) << bit_sel;
    new_word   = alloc_q ? (cur_word | bit_onehot) : (cur_word & ~bit_onehot);
    new_full   = &(new_word | word_pad);
  end

  // Memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = word_pick;
    if (mstate_q == M_IDLE && req_i.start && !req_i.alloc) begin
      mem_re    = 1'b1;
      mem_raddr = req_i.idx[dsa_pkg::WORD_AW+dsa_pkg::BIT_AW-1:dsa_pkg::BIT_AW];
    end else if (mstate_q == M_WORD) begin
      mem_re = 1'b1;
    end
    mem_we = (mstate_q == M_MOD);
  end

  // Word memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      used_mem[widx_q] <= new_word;
    end
    if (mem_re) begin
      rd_q <= used_mem[mem_raddr];
    end
  end

  // Sequencer and summary bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstate_q     <= M_IDLE;
      word_valid_q <= '0;
      word_full_q  <= '0;
      group_full_q <= '0;
      grp_q        <= '0;
      widx_q       <= '0;
      bit_q        <= '0;
      alloc_q      <= 1'b0;
    end else begin
      group_full_q <= group_full_d;
      unique case (mstate_q)
        M_IDLE: begin
          if (req_i.start) begin
            alloc_q <= req_i.alloc;
            if (req_i.alloc) begin
              mstate_q <= M_GROUP;
            end else begin
              widx_q   <= mem_raddr;
              bit_q    <= req_i.idx[dsa_pkg::BIT_AW-1:0];
              mstate_q <= M_MOD;
            end
          end
        end
        M_GROUP: begin
          if (grp_any) begin
            grp_q    <= grp_pick;
            mstate_q <= M_WORD;
          end else begin
            mstate_q <= M_IDLE;
          end
        end
        M_WORD: begin
          widx_q   <= word_pick;
          mstate_q <= M_MOD;
        end
        M_MOD: begin
          word_valid_q[widx_q] <= 1'b1;
          word_full_q[widx_q]  <= new_full;
          mstate_q             <= M_IDLE;
        end
        default: mstate_q <= M_IDLE;
      endcase
    end
  end

  // Report completion; a full table ends in the group step
  assign resp_o.done = (mstate_q == M_MOD) || (mstate_q == M_GROUP && !grp_any);
  assign resp_o.ok   = (mstate_q == M_MOD);
  assign resp_o.idx  = dsa_pkg::IDX_W'({widx_q, bit_sel});

endmodule

`default_nettype wire
